>>> hdl/qsu_pkg.sv
// Shared types and constants for the quoted string unescaper.
// Holds the channel payload structs, result kinds, escape phases and character codes.
// Has no dependencies.
`default_nettype none

package qsu_pkg;

  localparam int CNT_W = 16;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_NOEND = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_OCT1  = 2'd2,
    PH_OCT2  = 2'd3
  } phase_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_HT = 8'h09;
  localparam logic [7:0] BYTE_FF = 8'h0C;

  typedef struct packed {
    logic [7:0] char_in;
    logic       first_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] consumed;
    logic [CNT_W-1:0] stored_count;
    logic             final_result;
  } out_item_t;

  // Literal state other than the character position, whose width is a parameter.
  typedef struct packed {
    phase_t           phase;
    logic [7:0]       octal;
    logic [CNT_W-1:0] bytes;
    logic             finished;
  } lit_state_t;

endpackage

`default_nettype wire

>>> hdl/quoted_string_unescaper.sv
// Top level of the quoted string unescaper: input register, literal state and result queue.
// Depends on qsu_pkg, qsu_decode and qsu_outbuf.
`default_nettype none

// Decodes a double-quoted C-style string literal that arrives one character per
// transfer. The input channel takes one character every cycle unless it stalls.
// A character is first captured in an input register. Shallow combinational
// logic then decodes it once the queue has room, and its results are written
// into a four-entry result queue whose head drives the output channel. Most
// characters cause at most one result, and then the block sustains one
// character per cycle while the output side does not stall. A character that
// both stores a byte and carries the last-character mark without closing the
// literal causes two results (the data byte and the missing-end-quote result).
// The output channel moves one result per cycle while not stalled, so such
// characters take two output transfers. The input side stalls only while a
// character waits in the input register and the queue cannot take two more
// results. The capacity register is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle, which the block itself
// does not enforce. It resets to 65535. Characters after a final result are
// ignored until the next first-character mark. POSITION_BITS sets the width of
// the internal character counter, which saturates; the reported consumed count
// saturates at 65535.
module quoted_string_unescaper import qsu_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  // Input register.
  logic     in_vld_r, in_vld_nxt;
  in_item_t in_r;
  logic     in_accept;

  // Literal state and capacity register.
  lit_state_t               st_r, st_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]         cap_r;

  // Decode results and queue control.
  logic      res0_vld, res1_vld;
  out_item_t res0, res1;
  logic      room2;
  logic      fire;

  // The registered character is decoded once the queue can take both of its
  // possible results.
  assign fire       = in_vld_r && room2;
  assign in_stall   = in_vld_r && !room2;
  assign in_accept  = in_valid && !in_stall;
  assign in_vld_nxt = in_accept || (in_vld_r && !fire);

  qsu_decode #(
    .POSITION_BITS(POSITION_BITS)
  ) u_decode (
    .item     (in_r),
    .cur      (st_r),
    .pos      (pos_r),
    .capacity (cap_r),
    .nxt      (st_nxt),
    .pos_nxt  (pos_nxt),
    .res0_vld (res0_vld),
    .res0     (res0),
    .res1_vld (res1_vld),
    .res1     (res1)
  );

  qsu_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (fire && res0_vld),
    .push0_data (res0),
    .push1      (fire && res1_vld),
    .push1_data (res1),
    .room2      (room2),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '{phase: PH_PLAIN, octal: 8'd0, bytes: '0, finished: 1'b1};
      pos_r    <= '0;
      cap_r    <= {CNT_W{1'b1}};
    end else begin
      in_vld_r <= in_vld_nxt;
      if (fire) begin
        st_r  <= st_nxt;
        pos_r <= pos_nxt;
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // The input register is a payload register and only loads on a transfer.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
  end

  // The input side only stalls while a character waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with an empty input register");

  // A second result from one character is always a data byte then a missing end quote.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res1_vld) |-> (res0_vld && res0.kind == KIND_DATA &&
                            res1.kind == KIND_NOEND))
    else $error("bad pairing of two results from one character");

  // Within a literal the stored count never goes down.
  a_bytes_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !in_r.first_char) |=> (st_r.bytes >= $past(st_r.bytes)))
    else $error("stored byte count decreased inside a literal");

  // A final result always marks the literal finished.
  a_final_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res0_vld && res0.final_result) |=> st_r.finished)
    else $error("final result did not finish the literal");

endmodule

`default_nettype wire

>>> hdl/qsu_decode.sv
// Per-character decode logic: next literal state and up to two results.
// Purely combinational; depends on qsu_pkg.
`default_nettype none

module qsu_decode import qsu_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  in_item_t                 item,
  input  lit_state_t               cur,
  input  logic [POSITION_BITS-1:0] pos,
  input  logic [CNT_W-1:0]         capacity,
  output lit_state_t               nxt,
  output logic [POSITION_BITS-1:0] pos_nxt,
  output logic                     res0_vld,
  output out_item_t                res0,
  output logic                     res1_vld,
  output out_item_t                res1
);

  logic [POSITION_BITS-1:0] pos_bump;
  logic [CNT_W-1:0]         consumed_sat;
  logic                     is_oct;
  logic [2:0]               digit;
  logic                     emit;
  logic [7:0]               emit_byte;
  logic                     stop;
  logic                     stored;
  logic [CNT_W-1:0]         bytes_inc;

  assign pos_bump = (&pos) ? pos : pos + POSITION_BITS'(1);
  assign is_oct   = (item.char_in[7:3] == CH_ZERO[7:3]);
  assign digit    = item.char_in[2:0];

  // Consumed count saturates at the width of the result field.
  if (POSITION_BITS > CNT_W) begin : g_sat
    assign consumed_sat = (|pos_bump[POSITION_BITS-1:CNT_W]) ? {CNT_W{1'b1}}
                                                              : pos_bump[CNT_W-1:0];
  end else begin : g_ext
    assign consumed_sat = CNT_W'(pos_bump);
  end

  always_comb begin
    nxt       = cur;
    pos_nxt   = pos;
    emit      = 1'b0;
    emit_byte = item.char_in;
    stop      = 1'b0;
    stored    = 1'b0;
    bytes_inc = cur.bytes + CNT_W'(1);
    res0_vld  = 1'b0;
    res1_vld  = 1'b0;
    res0      = '{kind: KIND_DATA, data_byte: 8'd0, consumed: '0,
                  stored_count: cur.bytes, final_result: 1'b0};
    res1      = '{kind: KIND_NOEND, data_byte: 8'd0, consumed: '0,
                  stored_count: cur.bytes, final_result: 1'b1};

    if (item.first_char) begin
      // A first-character mark always restarts the literal.
      nxt.phase    = PH_PLAIN;
      nxt.octal    = 8'd0;
      nxt.bytes    = '0;
      nxt.finished = 1'b0;
      pos_nxt      = POSITION_BITS'(1);
      res0.stored_count = '0;
      if (item.char_in != CH_QUOTE) begin
        res0_vld          = 1'b1;
        res0.kind         = KIND_BAD;
        res0.final_result = 1'b1;
        nxt.finished      = 1'b1;
      end else if (item.last_char) begin
        res0_vld          = 1'b1;
        res0.kind         = KIND_NOEND;
        res0.final_result = 1'b1;
        nxt.finished      = 1'b1;
      end
    end else if (!cur.finished) begin
      pos_nxt = pos_bump;
      unique case (cur.phase)
        PH_PLAIN: begin
          if (item.char_in == CH_BSLASH) begin
            nxt.phase = PH_ESC;
          end else if (item.char_in == CH_QUOTE) begin
            stop              = 1'b1;
            res0_vld          = 1'b1;
            res0.kind         = KIND_DONE;
            res0.consumed     = consumed_sat;
            res0.final_result = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
        PH_ESC: begin
          if (is_oct) begin
            nxt.octal = {digit[1:0], 6'd0};
            nxt.phase = PH_OCT1;
          end else begin
            nxt.phase = PH_PLAIN;
            emit      = 1'b1;
            case (item.char_in)
              CH_N:      emit_byte = BYTE_LF;
              CH_R:      emit_byte = BYTE_CR;
              CH_B:      emit_byte = BYTE_BS;
              CH_T:      emit_byte = BYTE_HT;
              CH_F:      emit_byte = BYTE_FF;
              CH_BSLASH: emit_byte = CH_BSLASH;
              CH_QUOTE:  emit_byte = CH_QUOTE;
              default: begin
                emit      = 1'b0;
                stop      = 1'b1;
                nxt.phase = cur.phase;
              end
            endcase
          end
        end
        PH_OCT1: begin
          if (is_oct) begin
            nxt.octal = cur.octal | {2'd0, digit, 3'd0};
            nxt.phase = PH_OCT2;
          end else begin
            stop = 1'b1;
          end
        end
        PH_OCT2: begin
          if (is_oct) begin
            nxt.octal = cur.octal | {5'd0, digit};
            nxt.phase = PH_PLAIN;
            emit      = 1'b1;
            emit_byte = cur.octal | {5'd0, digit};
          end else begin
            stop = 1'b1;
          end
        end
        default: stop = 1'b1;
      endcase

      if (stop && !res0_vld) begin
        res0_vld          = 1'b1;
        res0.kind         = KIND_BAD;
        res0.final_result = 1'b1;
      end
      if (stop) begin
        nxt.finished = 1'b1;
      end

      // Bytes past the capacity are dropped without a result.
      if (emit && (cur.bytes < capacity)) begin
        stored            = 1'b1;
        nxt.bytes         = bytes_inc;
        res0_vld          = 1'b1;
        res0.data_byte    = emit_byte;
        res0.stored_count = bytes_inc;
      end

      if (!stop && item.last_char) begin
        nxt.finished = 1'b1;
        if (stored) begin
          res1_vld          = 1'b1;
          res1.stored_count = bytes_inc;
        end else begin
          res0_vld          = 1'b1;
          res0.kind         = KIND_NOEND;
          res0.final_result = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/qsu_outbuf.sv
// Four-entry result queue that takes up to two results per cycle.
// Depends on qsu_pkg for the result struct.
`default_nettype none

module qsu_outbuf import qsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push0,
  input  out_item_t push0_data,
  input  logic      push1,
  input  out_item_t push1_data,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  out_item_t            mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 pop;
  logic [PTR_W-1:0]     wr_ptr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room2     = (cnt_r <= CNT_BITS'(DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push0) + PTR_W'(push1);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_BITS'(push0) + CNT_BITS'(push1) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= push0_data;
    end
    if (push1) begin
      mem_r[wr_ptr_p1] <= push1_data;
    end
  end

endmodule

`default_nettype wire

>>> sim/qsu_checker.sv
// Checker for the quoted string unescaper: follows both channels and the capacity port,
// predicts the results of every accepted character and compares them in order.
// Depends on qsu_pkg.

module qsu_checker import qsu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  output int               mismatches,
  output int               results_owed
);

  // Beyond this many reports the failures are still counted but not printed.
  localparam int REPORT_CAP = 200;

  logic [CNT_W-1:0] capacity;
  phase_t           phase;
  logic [7:0]       octal;
  logic [CNT_W-1:0] position;
  logic [CNT_W-1:0] bytes;
  logic             finished;
  out_item_t        unescaped_q[$];
  int               fail_total;

  task automatic advance_position();
    if (position != {CNT_W{1'b1}}) position = position + CNT_W'(1);
  endtask

  task automatic close_literal(input kind_t kind, input logic [CNT_W-1:0] used);
    unescaped_q.push_back('{kind: kind, data_byte: 8'h00, consumed: used,
                            stored_count: bytes, final_result: 1'b1});
    finished = 1'b1;
  endtask

  // A decoded byte is kept only while the count is below the capacity.
  task automatic store_byte(input logic [7:0] value);
    if (bytes < capacity) begin
      bytes = bytes + CNT_W'(1);
      unescaped_q.push_back('{kind: KIND_DATA, data_byte: value, consumed: '0,
                              stored_count: bytes, final_result: 1'b0});
    end
  endtask

  task automatic unescape_char(input in_item_t item);
    logic [7:0] c;
    logic [2:0] digit;
    logic       is_digit;
    logic [7:0] decoded;
    c = item.char_in;
    digit = c[2:0];
    is_digit = (c >= CH_ZERO) && (c <= CH_ZERO + 8'd7);
    if (item.first_char) begin
      phase = PH_PLAIN;
      octal = '0;
      position = '0;
      bytes = '0;
      finished = 1'b0;
      advance_position();
      if (c != CH_QUOTE) close_literal(KIND_BAD, '0);
      else if (item.last_char) close_literal(KIND_NOEND, '0);
      return;
    end
    if (finished) return;
    advance_position();
    case (phase)
      PH_PLAIN: begin
        if (c == CH_BSLASH) begin
          phase = PH_ESC;
        end else if (c == CH_QUOTE) begin
          close_literal(KIND_DONE, position);
          return;
        end else begin
          store_byte(c);
        end
      end
      PH_ESC: begin
        if (is_digit) begin
          // The first of three digits keeps only its two low bits after the wrap.
          octal = {digit[1:0], 6'b0};
          phase = PH_OCT1;
        end else begin
          case (c)
            CH_N:      decoded = BYTE_LF;
            CH_R:      decoded = BYTE_CR;
            CH_B:      decoded = BYTE_BS;
            CH_T:      decoded = BYTE_HT;
            CH_F:      decoded = BYTE_FF;
            CH_BSLASH: decoded = CH_BSLASH;
            CH_QUOTE:  decoded = CH_QUOTE;
            default: begin
              close_literal(KIND_BAD, '0);
              return;
            end
          endcase
          phase = PH_PLAIN;
          store_byte(decoded);
        end
      end
      PH_OCT1: begin
        if (!is_digit) begin
          close_literal(KIND_BAD, '0);
          return;
        end
        octal[5:3] = digit;
        phase = PH_OCT2;
      end
      default: begin
        if (!is_digit) begin
          close_literal(KIND_BAD, '0);
          return;
        end
        octal[2:0] = digit;
        phase = PH_PLAIN;
        store_byte(octal);
      end
    endcase
    if (item.last_char) close_literal(KIND_NOEND, '0);
  endtask

  function automatic string describe(input out_item_t r);
    return $sformatf("kind %0d byte %02h used %0d stored %0d final %0b",
                     r.kind, r.data_byte, r.consumed, r.stored_count, r.final_result);
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (unescaped_q.size() == 0) begin
      fail_total++;
      if (fail_total <= REPORT_CAP)
        $display("%0t: unexpected result, expected none, got kind %0d byte %02h",
                 $time, got.kind, got.data_byte);
      return;
    end
    want = unescaped_q.pop_front();
    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
        got.consumed !== want.consumed || got.stored_count !== want.stored_count ||
        got.final_result !== want.final_result) begin
      fail_total++;
      if (fail_total <= REPORT_CAP)
        $display("%0t: expected %s, got %s", $time, describe(want), describe(got));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity = {CNT_W{1'b1}};
      phase = PH_PLAIN;
      octal = '0;
      position = '0;
      bytes = '0;
      finished = 1'b1;
      unescaped_q.delete();
      fail_total = 0;
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (in_valid && !in_stall) unescape_char(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    results_owed <= unescaped_q.size();
    mismatches <= fail_total;
  end

endmodule

>>> sim/quoted_string_unescaper_tb.sv
// Testbench top for the quoted string unescaper: clock, reset, character stimulus,
// capacity writes, random stalls on the result side and the verdict.
// Depends on qsu_pkg, quoted_string_unescaper and qsu_checker.

module quoted_string_unescaper_tb;
  import qsu_pkg::*;

  // Run-time guard. It lies above the length of a correct run, even with every
  // character giving two results under the longest gaps and output stalls.
  localparam int CYCLE_LIMIT = 400000;
  // Characters per random phase; six phases and the directed part come to about
  // 850 characters.
  localparam int PHASE_ITEMS = 130;
  // Cycles allowed after the last owed result for a character still in the pipeline.
  localparam int SETTLE_CYCLES = 6;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  int mismatches;
  int results_owed;
  int cycles = 0;
  int chars_sent = 0;
  int stall_left = 0;
  // While calm is set neither side inserts gaps, so the block runs at full rate.
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quoted_string_unescaper i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  qsu_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // Gap lengths: about half the time none, otherwise mostly short, now and then a long one; none while calm is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Any character that does not start an escape or close the literal.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] escape_letter(input int sel);
    case (sel)
      0:       return CH_N;
      1:       return CH_R;
      2:       return CH_B;
      3:       return CH_T;
      4:       return CH_F;
      5:       return CH_BSLASH;
      default: return CH_QUOTE;
    endcase
  endfunction

  // The result side stalls in bursts of random length, drawn at random moments.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left <= pick_gap();
    end
  end

  // Global timeout: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One character transfer. Valid is lowered only for a gap, so back-to-back
  // transfers keep it high, and the payload holds while the block stalls.
  task automatic send_char(input logic [7:0] c, input logic first, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_in: c, first_char: first, last_char: last};
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  // Sends a character sequence; opening marks its first character as the start
  // of a literal and closing marks its final character as the end of the text.
  task automatic send_chars(input logic [7:0] txt[$], input bit opening, input bit closing);
    for (int k = 0; k < txt.size(); k++)
      send_char(txt[k], opening && k == 0, closing && k == txt.size() - 1);
  endtask

  task automatic send_text(input string s, input bit opening, input bit closing);
    logic [7:0] txt[$];
    for (int k = 0; k < s.len(); k++) txt.push_back(s[k]);
    send_chars(txt, opening, closing);
  endtask

  // Holds off the sender until every owed result has been taken, then lets the
  // pipeline empty. The first wait lets the count reflect the last transfer.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Builds one literal with random plain characters, simple escapes and octal
  // escapes. Most come out well formed; the rest are damaged in a few ways:
  // a random character overwritten, the text cut short with the end mark, the
  // text cut short without it so the next literal restarts over it, or a
  // backslash pair inserted that is usually not a known escape.
  task automatic random_literal();
    logic [7:0] txt[$];
    int         count;
    int         r;
    int         pos;
    bit         end_mark;
    txt.push_back(CH_QUOTE);
    count = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        txt.push_back(plain_char());
      end else if (r < 8) begin
        txt.push_back(CH_BSLASH);
        txt.push_back(escape_letter($urandom_range(0, 6)));
      end else begin
        txt.push_back(CH_BSLASH);
        repeat (3) txt.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
      end
    end
    txt.push_back(CH_QUOTE);
    end_mark = ($urandom_range(0, 9) == 0);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      pos = $urandom_range(0, txt.size() - 1);
      txt[pos] = 8'($urandom_range(0, 255));
    end else if (r < 14 || r >= 96) begin
      pos = $urandom_range(0, txt.size() - 2);
      while (txt.size() > pos + 1) void'(txt.pop_back());
      end_mark = (r < 14);
    end else if (r < 19) begin
      pos = $urandom_range(1, txt.size() - 1);
      txt.insert(pos, 8'($urandom_range(0, 255)));
      txt.insert(pos, CH_BSLASH);
    end
    send_chars(txt, 1'b1, end_mark);
    // Stray characters between literals are ignored once the literal is over.
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  task automatic random_phase();
    int start;
    start = chars_sent;
    while (chars_sent - start < PHASE_ITEMS) random_literal();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset capacity. Every escape letter, an octal escape
    // at the top of the byte range and a zero byte, then a restart over the open
    // literal that runs into an unknown escape.
    send_text("\"\\n\\r\\b\\t\\f\\\\\\\"\\377", 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_text("\"\\9", 1'b1, 1'b0);
    // A non-digit where the second octal digit is due.
    send_text("\"\\18", 1'b1, 1'b0);
    // Bad first character, then a character that arrives with no literal open.
    send_text("x", 1'b1, 1'b0);
    send_text("q", 1'b0, 1'b0);
    // A lone opening quote that is also the end of the text.
    send_text("\"", 1'b1, 1'b1);
    // A data byte and the missing end quote from the same character.
    send_text("\"a", 1'b1, 1'b1);
    // The empty literal closes with two characters consumed.
    send_text("\"\"", 1'b1, 1'b0);

    // Capacity lowered below the count of an open literal: the count stays and
    // nothing more is stored until the literal closes.
    settle();
    send_text("\"abcde", 1'b1, 1'b0);
    settle();
    write_capacity(16'd2);
    send_text("fg\\n\"", 1'b0, 1'b0);

    // Random phases over several capacities, the extremes among them. Each
    // capacity change waits for the block to go idle.
    settle();
    write_capacity('0);
    random_phase();
    settle();
    write_capacity(16'd1);
    calm = 1'b1;
    random_phase();
    calm = 1'b0;
    settle();
    write_capacity(16'd4);
    random_phase();
    // The sender pauses between two phases at the same capacity until everything owed has arrived.
    settle();
    random_phase();
    settle();
    write_capacity(16'($urandom_range(0, 16)));
    random_phase();
    settle();
    write_capacity({CNT_W{1'b1}});
    random_phase();

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
